// File: design/rmts_pkg.sv
// Shared types, constants and helpers for the rate-monotonic tick scheduler.
// Used by rmts_regs, rmts_sched and rate_monotonic_tick_scheduler.
`default_nettype none

package rmts_pkg;

  // Task slots, counter width and register geometry
  localparam int NumSlots   = 4;
  localparam int NumTasks   = 4;
  localparam int CountWidth = 16;
  localparam int RegWidth   = 16;
  localparam int TimeWidth  = 32;
  localparam int TaskIdxW   = 2;
  localparam int RegIdxW    = $clog2(2 * NumSlots);
  localparam int AddrWidth  = RegIdxW + 2;
  localparam int DataWidth  = 32;

  // Register indexes
  localparam logic [RegIdxW-1:0] RegPeriod0 = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegBudget0 = RegIdxW'(NumSlots);

  typedef logic [RegWidth-1:0]   reg_word_t;
  typedef reg_word_t [NumSlots-1:0] reg_bank_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [TimeWidth-1:0]  time_t;

  // One scheduling decision
  typedef struct packed {
    logic [TaskIdxW-1:0] running_task;
    logic                busy;
    logic [NumSlots-1:0] release_mask;
    time_t               tick_time;
  } sched_res_t;

  // Fit a register value to the counter width
  function automatic count_t to_count(reg_word_t v);
    logic [CountWidth+RegWidth-1:0] wide;
    wide = {{CountWidth{1'b0}}, v};
    return wide[CountWidth-1:0];
  endfunction

  // Period as used by the counters: zero acts as one
  function automatic count_t eff_period(reg_word_t v);
    count_t p;
    p = to_count(v);
    return (p == '0) ? count_t'(1) : p;
  endfunction

endpackage

`default_nettype wire

// File: design/rmts_regs.sv
// APB-style register file holding task periods and budgets.
// Depends on rmts_pkg for register geometry and index constants.
`default_nettype none

module rmts_regs
  import rmts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready,
  output reg_bank_t                 periods,
  output reg_bank_t                 budgets
);

  reg_bank_t period_r, period_nxt;
  reg_bank_t budget_r, budget_nxt;
  logic [RegIdxW-1:0] reg_idx;
  logic [TaskIdxW-1:0] slot;
  logic wr_en;

  assign reg_idx = paddr[AddrWidth-1:2];
  assign slot    = reg_idx[TaskIdxW-1:0];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Decode the write transaction
  always_comb begin
    period_nxt = period_r;
    budget_nxt = budget_r;
    if (wr_en) begin
      if (reg_idx < RegBudget0) begin
        period_nxt[slot] = pwdata[RegWidth-1:0];
      end else begin
        budget_nxt[slot] = pwdata[RegWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumSlots; i++) begin
        period_r[i] <= '1;
        budget_r[i] <= '0;
      end
    end else begin
      period_r <= period_nxt;
      budget_r <= budget_nxt;
    end
  end

  // Read back the addressed register; periods sit below the first budget
  always_comb begin
    if (reg_idx < RegBudget0) begin
      prdata = DataWidth'(period_r[slot]);
    end else begin
      prdata = DataWidth'(budget_r[slot]);
    end
  end

  assign periods = period_r;
  assign budgets = budget_r;

endmodule

`default_nettype wire

// File: design/rmts_sched.sv
// Scheduler state (remaining budgets, phases, time) and the per-tick decision.
// Depends on rmts_pkg for types and counter helpers.
`default_nettype none

module rmts_sched
  import rmts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       restart,
  input  wire reg_bank_t  periods,
  input  wire reg_bank_t  budgets,
  output sched_res_t      res
);

  count_t remaining_r [NumTasks];
  count_t remaining_nxt [NumTasks];
  count_t phase_r [NumTasks];
  count_t phase_nxt [NumTasks];
  time_t  time_r, time_nxt;

  count_t rem_rel [NumTasks];
  count_t eff_p [NumTasks];
  logic [NumTasks-1:0] rel_vec;
  logic [NumTasks-1:0] dec_vec;
  time_t now;
  logic busy;
  logic [TaskIdxW-1:0] run;
  count_t best;
  logic [CountWidth:0] ph_inc;

  always_comb begin
    now     = restart ? '0 : time_r;
    busy    = 1'b0;
    run     = '0;
    best    = '0;
    ph_inc  = '0;
    rel_vec = '0;
    dec_vec = '0;

    // Release tasks whose phase is zero (not at time zero), reload their budgets; a restart reloads all
    for (int i = 0; i < NumTasks; i++) begin
      eff_p[i]   = eff_period(periods[i]);
      rel_vec[i] = (now != '0) && (restart || phase_r[i] == '0);
      if (restart || rel_vec[i]) begin
        rem_rel[i] = to_count(budgets[i]);
      end else begin
        rem_rel[i] = remaining_r[i];
      end
    end

    // Pick the ready task with the shortest period, lower index on ties
    for (int i = 0; i < NumTasks; i++) begin
      if (rem_rel[i] != '0 && (!busy || eff_p[i] < best)) begin
        busy = 1'b1;
        best = eff_p[i];
        run  = TaskIdxW'(i);
      end
    end

    // Burn one tick of budget, advance the phases
    for (int i = 0; i < NumTasks; i++) begin
      dec_vec[i]       = busy && (run == TaskIdxW'(i));
      remaining_nxt[i] = dec_vec[i] ? rem_rel[i] - count_t'(1) : rem_rel[i];
      ph_inc           = {1'b0, (restart ? count_t'(0) : phase_r[i])} + 1'b1;
      phase_nxt[i]     = (ph_inc >= {1'b0, eff_p[i]}) ? '0 : ph_inc[CountWidth-1:0];
    end
    time_nxt = now + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumTasks; i++) begin
        remaining_r[i] <= '0;
        phase_r[i]     <= '0;
      end
      time_r <= '0;
    end else if (step) begin
      remaining_r <= remaining_nxt;
      phase_r     <= phase_nxt;
      time_r      <= time_nxt;
    end
  end

  assign res.running_task = run;
  assign res.busy         = busy;
  assign res.release_mask = NumSlots'(rel_vec);
  assign res.tick_time    = now;

`ifndef ASSERT_OFF
  a_one_dec: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> $onehot0(dec_vec))
    else $error("more than one task charged in one tick");
  a_busy_dec: assert property (@(posedge clk) disable iff (!rst_n)
    step && busy |-> $countones(dec_vec) == 1)
    else $error("busy tick charged no task");
  a_time_adv: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> time_r == $past(now) + 1'b1)
    else $error("time did not advance by one");
`endif

endmodule

`default_nettype wire

// File: design/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler, top level: input stage, scheduler, result register.
// A tick waits in the input stage, then its decision is registered in the result register.
// Throughput: one tick per cycle unless stalled; state updates once per tick, in one pass.
// Reset (rst_n low, synchronous): both stages empty, time, phases and budgets cleared,
// periods set to 65535 and budgets to 0. Depends on rmts_pkg, rmts_regs, rmts_sched.
`default_nettype none

module rate_monotonic_tick_scheduler
  import rmts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_restart,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TaskIdxW-1:0]       out_running_task,
  output logic                      out_busy_res,
  output logic [NumSlots-1:0]       out_release_mask,
  output logic [TimeWidth-1:0]      out_tick_time,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic      [DataWidth-1:0] prdata,
  output logic                      pready
);

  reg_bank_t  periods, budgets;
  sched_res_t res;
  sched_res_t res_r;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_restart_r;
  logic out_valid_r, out_valid_nxt;
  logic accept, advance;

  rmts_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .periods (periods),
    .budgets (budgets)
  );

  rmts_sched u_sched (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .restart (s1_restart_r),
    .periods (periods),
    .budgets (budgets),
    .res     (res)
  );

  // Move the held tick forward when the result slot is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign s1_valid_nxt  = accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_restart_r <= in_restart;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_running_task = res_r.running_task;
  assign out_busy_res     = res_r.busy;
  assign out_release_mask = res_r.release_mask;
  assign out_tick_time    = res_r.tick_time;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("held tick did not move to the result register");
  a_zero_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tick_time == '0 |-> out_release_mask == '0)
    else $error("release reported at time zero");
  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_busy_res |-> out_running_task == '0)
    else $error("idle tick names a task");
`endif

endmodule

`default_nettype wire

// File: tb/sv/rate_monotonic_tick_scheduler_test.sv
// Testbench for the rate-monotonic tick scheduler: random-gap tick driver, result monitor,
// APB register writes and a cycle-level scheduling predictor checked against every result.
// Depends on rmts_pkg and the rate_monotonic_tick_scheduler RTL.
`timescale 1ns / 100ps

module rate_monotonic_tick_scheduler_test;
  import rmts_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TaskIdxW-1:0]  out_running_task;
  logic                 out_busy_res;
  logic [NumSlots-1:0]  out_release_mask;
  logic [TimeWidth-1:0] out_tick_time;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  rate_monotonic_tick_scheduler u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_running_task (out_running_task),
    .out_busy_res     (out_busy_res),
    .out_release_mask (out_release_mask),
    .out_tick_time    (out_tick_time),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Pending ticks (restart flag) and expected scheduling decisions
  bit         tick_q[$];
  sched_res_t decision_q[$];

  // Predictor copy of registers and scheduler state
  reg_word_t cfg_period[NumSlots];
  reg_word_t cfg_budget[NumSlots];
  count_t    left_cnt[NumSlots];
  count_t    phase_cnt[NumSlots];
  time_t     now_time;

  // Register plan for the next configuration phase
  reg_word_t plan_period[NumSlots];
  reg_word_t plan_budget[NumSlots];

  bit          in_fire = 1'b0;
  bit          jitter_on = 1'b1;
  bit          long_stall_req = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  int unsigned err_count = 0;
  int unsigned ticks_checked = 0;
  int unsigned restarts_sent = 0;
  int unsigned busy_ticks = 0;
  int unsigned release_bits = 0;
  int unsigned settings_used = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Counter period as the scheduler uses it: zero acts as one
  function automatic int unsigned active_period(int idx);
    int unsigned p;
    p = 32'(count_t'(cfg_period[idx]));
    return (p == 0) ? 1 : p;
  endfunction

  // Advance the scheduler by one tick and return its decision
  function automatic sched_res_t schedule_tick(bit restart);
    sched_res_t  r;
    int unsigned best, per, nx;
    int          i;
    r = '0;
    best = 0;
    if (restart) begin
      now_time = '0;
      for (i = 0; i < NumSlots; i++) begin
        phase_cnt[i] = '0;
        left_cnt[i] = count_t'(cfg_budget[i]);
      end
    end
    r.tick_time = now_time;
    // release tasks whose phase wrapped; leftover budget is dropped
    for (i = 0; i < NumTasks; i++) begin
      if (now_time != '0 && phase_cnt[i] == '0) begin
        r.release_mask[i] = 1'b1;
        left_cnt[i] = count_t'(cfg_budget[i]);
      end
    end
    // shortest period wins, lower index on ties
    for (i = 0; i < NumTasks; i++) begin
      if (left_cnt[i] != '0) begin
        per = active_period(i);
        if (!r.busy || per < best) begin
          r.busy = 1'b1;
          best = per;
          r.running_task = TaskIdxW'(i);
        end
      end
    end
    if (r.busy) left_cnt[r.running_task] = left_cnt[r.running_task] - 1'b1;
    // advance phases, wrapping at or above the period
    for (i = 0; i < NumTasks; i++) begin
      nx = int'(phase_cnt[i]) + 1;
      phase_cnt[i] = (nx >= active_period(i)) ? '0 : count_t'(nx);
    end
    now_time = now_time + 1'b1;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Check results against the oldest decision, then predict for accepted ticks
  always @(posedge clk) begin
    sched_res_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      ticks_checked++;
      if (out_busy_res) busy_ticks++;
      release_bits += $countones(out_release_mask);
      if (decision_q.size() == 0) begin
        $error("unexpected transaction: task %0d busy %0d mask %0h time %0d",
               out_running_task, out_busy_res, out_release_mask, out_tick_time);
        err_count++;
      end else begin
        want = decision_q.pop_front();
        check_field("running_task", want.running_task, out_running_task);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("release_mask", want.release_mask, out_release_mask);
        check_field("tick_time", want.tick_time, out_tick_time);
      end
    end
    if (in_fire) begin
      if (in_restart) restarts_sent++;
      decision_q = {decision_q, schedule_tick(in_restart)};
    end
  end

  // Tick driver: advance after each accepted transaction, with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (tx_gap == 0 && jitter_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 3);
        if (tx_gap > 0 || tick_q.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_restart <= tick_q.pop_front();
        end
      end
    end
  end

  // Result stall: short random bursts, or one long hold on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        rx_hold = 60;
      end else if (rx_hold == 0 && jitter_on && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(1, 3);
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // APB write: setup cycle, access cycle, then release the bus
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input reg_word_t value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = DataWidth'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (idx < RegBudget0) cfg_period[idx] = value;
    else cfg_budget[idx - RegBudget0] = value;
  endtask

  task automatic write_all_regs();
    int i;
    for (i = 0; i < NumSlots; i++) begin
      write_reg(RegIdxW'(RegPeriod0 + i), plan_period[i]);
      write_reg(RegIdxW'(RegBudget0 + i), plan_budget[i]);
    end
    settings_used++;
  endtask

  // Hold until every tick is accepted and every decision has come back
  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || decision_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic reg_word_t pick_period();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return reg_word_t'($urandom_range(1, 65535));
      3: return reg_word_t'(1);
      default: return reg_word_t'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic reg_word_t pick_budget();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2: return reg_word_t'($urandom_range(0, 65535));
      default: return reg_word_t'($urandom_range(0, 4));
    endcase
  endfunction

  initial begin
    int ph, k, i;
    for (i = 0; i < NumSlots; i++) begin
      cfg_period[i] = '1;
      cfg_budget[i] = '0;
      left_cnt[i] = '0;
      phase_cnt[i] = '0;
    end
    now_time = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: no budgets, so every tick idles, restart included
    tick_q = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    wait_drained();

    // Zero period acting as one, zero budget released every tick, full budget and period
    plan_period = '{16'd4, 16'd0, 16'd6, 16'hFFFF};
    plan_budget = '{16'd1, 16'd0, 16'd3, 16'hFFFF};
    write_all_regs();
    tick_q = {tick_q, 1'b1};
    repeat (13) tick_q = {tick_q, 1'b0};
    wait_drained();

    // Shrink a period to no more than the current phase; a budget write must not reload
    write_reg(RegIdxW'(RegPeriod0 + 2), reg_word_t'(2));
    write_reg(RegBudget0, reg_word_t'(5));
    repeat (5) tick_q = {tick_q, 1'b0};
    wait_drained();

    // Random settings: extreme highs, extreme lows, then mixed; last phase without gaps
    for (ph = 0; ph < 6; ph++) begin
      jitter_on = (ph != 5);
      for (i = 0; i < NumSlots; i++) begin
        case (ph)
          0: begin
            plan_period[i] = '1;
            plan_budget[i] = '1;
          end
          1: begin
            plan_period[i] = $urandom_range(0, 1) ? reg_word_t'(0) : reg_word_t'(1);
            plan_budget[i] = reg_word_t'($urandom_range(0, 1));
          end
          default: begin
            plan_period[i] = pick_period();
            plan_budget[i] = pick_budget();
          end
        endcase
      end
      write_all_regs();
      tick_q = {tick_q, ($urandom_range(0, 3) != 0)};
      for (k = 1; k < 165; k++) tick_q = {tick_q, ($urandom_range(0, 63) == 0)};
      // hold the result side while ticks keep coming, so the input backs up
      if (ph == 2) begin
        repeat (4) @(posedge clk);
        long_stall_req = 1'b1;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d ticks under %0d register settings with %0d restarts.",
             ticks_checked, settings_used, restarts_sent);
    $display("Saw %0d busy ticks, %0d idle ticks and %0d task releases.",
             busy_ticks, ticks_checked - busy_ticks, release_bits);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
